### src/kdbc_pkg.sv
// ----------------------------------------------------------------------------
// kdbc_pkg
// Types and command codes for the key debounce and beep cadence core.
// ----------------------------------------------------------------------------
`default_nettype none

package kdbc_pkg;

	localparam int KEY_W  = 8;
	localparam int CMD_W  = 2;
	localparam int SLOT_N = 3;

	localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	localparam logic [1:0] SLOT_TOP = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] pins;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] pressed_keys;
		logic [KEY_W-1:0] released_keys;
		logic             slow_tick;
		logic             tone_enable;
	} out_item_t;

endpackage

`default_nettype wire

### src/key_debounce_and_beep_cadence_core.sv
// ----------------------------------------------------------------------------
// key_debounce_and_beep_cadence_core
// Three-sample key debouncer with slow tick and beep cadence gating.
//
//   channel | signals                      | payload
//   in      | in_valid / in_ready          | in_item  (cmd, pins)
//   out     | out_valid / out_ready        | out_item (pressed, released,
//           |                              |           slow_tick, tone_enable)
//
// One item per cycle unless the result stalls. Items pass the input register,
// then the result register; state updates as the item moves into the result
// register. Reset clears history, reported keys, cadence and slot (slot = 2).
// A stalled result holds the input stage; one more item may wait there.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_and_beep_cadence_core
	import kdbc_pkg::*;
#(
	parameter int MARK_TICKS  = 3,
	parameter int SPACE_TICKS = 4,
	parameter int BURST_COUNT = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	localparam int CYCLE = MARK_TICKS + SPACE_TICKS;
	localparam int ON    = BURST_COUNT * CYCLE;
	localparam int TOTAL = 2 * ON;
	localparam int PW    = $clog2(TOTAL);
	localparam int RW    = (CYCLE > 1) ? $clog2(CYCLE) : 1;

	logic              valid_s1;
	in_item_t          item_s1;
	logic              adv;

	logic [KEY_W-1:0]  hist_q [SLOT_N];
	logic [KEY_W-1:0]  rep_q;
	logic [1:0]        slot_q;
	logic              beep_q;
	logic [PW-1:0]     phase_q;
	logic [RW-1:0]     rem_q;
	logic              tone_q;

	logic [1:0]        slot;
	logic [KEY_W-1:0]  hist_nx [SLOT_N];
	logic [KEY_W-1:0]  stable;
	logic [KEY_W-1:0]  report;
	logic [KEY_W-1:0]  rep_nx;
	logic [1:0]        slot_nx;
	logic              beep_nx;
	logic [PW:0]       ph_inc;
	logic [PW-1:0]     ph_step;
	logic [RW-1:0]     rem_step;
	logic [PW-1:0]     phase_nx;
	logic [RW-1:0]     rem_nx;
	logic              tone_nx;
	out_item_t         res;

	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		slot = (slot_q == 2'd3) ? SLOT_TOP : slot_q;
		for (int i = 0; i < SLOT_N; i++) begin
			hist_nx[i] = (item_s1.cmd == CMD_SCAN && slot == 2'(i)) ? item_s1.pins : hist_q[i];
		end
		stable  = ~((hist_nx[0] ^ hist_nx[1]) | (hist_nx[1] ^ hist_nx[2]));
		report  = stable & (item_s1.pins ^ rep_q);

		ph_inc   = {1'b0, phase_q} + {{PW{1'b0}}, 1'b1};
		ph_step  = (ph_inc == (PW+1)'(TOTAL)) ? '0 : ph_inc[PW-1:0];
		rem_step = (rem_q == RW'(CYCLE - 1)) ? '0 : rem_q + RW'(1);

		rep_nx   = rep_q;
		slot_nx  = slot_q;
		beep_nx  = beep_q;
		phase_nx = phase_q;
		rem_nx   = rem_q;
		tone_nx  = tone_q;
		res      = '0;

		case (item_s1.cmd)
			CMD_SCAN: begin
				rep_nx            = (rep_q & ~report) | (report & item_s1.pins);
				res.pressed_keys  = report & ~item_s1.pins;
				res.released_keys = report & item_s1.pins;
				res.slow_tick     = (slot == 2'd0);
				slot_nx           = (slot == 2'd0) ? SLOT_TOP : slot - 2'd1;
				if (beep_q) begin
					phase_nx = ph_step;
					rem_nx   = rem_step;
					if (ph_step < PW'(ON)) begin
						if (rem_step == '0) begin
							tone_nx = 1'b1;
						end else if (rem_step == RW'(MARK_TICKS)) begin
							tone_nx = 1'b0;
						end
					end
				end
			end
			CMD_START: begin
				beep_nx  = 1'b1;
				phase_nx = PW'(ON);
				rem_nx   = '0;
			end
			CMD_STOP: begin
				beep_nx = 1'b0;
				tone_nx = 1'b0;
			end
			default: begin
			end
		endcase
		res.tone_enable = tone_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_N; i++) begin
				hist_q[i] <= '0;
			end
			rep_q     <= '0;
			slot_q    <= SLOT_TOP;
			beep_q    <= 1'b0;
			phase_q   <= '0;
			rem_q     <= '0;
			tone_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				for (int i = 0; i < SLOT_N; i++) begin
					hist_q[i] <= hist_nx[i];
				end
				rep_q   <= rep_nx;
				slot_q  <= slot_nx;
				beep_q  <= beep_nx;
				phase_q <= phase_nx;
				rem_q   <= rem_nx;
				tone_q  <= tone_nx;
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= res;
		end
	end

endmodule

`default_nettype wire

### src/kdbc_checker.sv
// ----------------------------------------------------------------------------
// kdbc_checker
// Port-level checks for the key debounce and beep cadence core.
// ----------------------------------------------------------------------------
`default_nettype none

module kdbc_checker
	import kdbc_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// a key is never pressed and released in one item
	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.pressed_keys & out_item.released_keys) == '0)
		else $error("key both pressed and released");

	// input side only backs up behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a start item taken while the result stalls is not followed by a new rise of out_valid
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.cmd == CMD_START && out_valid && !out_ready
		|=> ##1 !(out_valid && $rose(out_valid)))
		else $error("spurious result after start");

endmodule

bind key_debounce_and_beep_cadence_core kdbc_checker u_kdbc_checker (.*);

`default_nettype wire

### tb/tb_key_debounce_and_beep_cadence_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_and_beep_cadence_core
// Self-checking bench for the key debounce and beep cadence core.
//
// Sends scan, beep start/stop and unused commands through the input channel.
// A cycle-free predictor of the debouncer and cadence tracks expected
// results, and every accepted result is compared field by field. Runs three
// throttling phases: receiver-heavy idling, sender-heavy idling, then none.
// ----------------------------------------------------------------------------

module tb_key_debounce_and_beep_cadence_core;
	import kdbc_pkg::*;

	localparam int MARK_TICKS  = 3;
	localparam int SPACE_TICKS = 4;
	localparam int BURST_COUNT = 4;
	localparam int CYCLE_LEN   = MARK_TICKS + SPACE_TICKS;
	localparam int ON_LEN      = BURST_COUNT * CYCLE_LEN;
	localparam int TOTAL_LEN   = 2 * ON_LEN;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;

	// predicted state
	logic [KEY_W-1:0] hist_q [SLOT_N];
	logic [KEY_W-1:0] reported_q;
	logic [1:0]       slot_q;
	logic             beep_on_q;
	int               phase_q;
	logic             tone_q;

	out_item_t pending_results [$];

	key_debounce_and_beep_cadence_core #(
		.MARK_TICKS (MARK_TICKS),
		.SPACE_TICKS(SPACE_TICKS),
		.BURST_COUNT(BURST_COUNT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic out_item_t next_debounce_result(in_item_t it);
		out_item_t        r;
		logic [1:0]       s;
		logic [KEY_W-1:0] cur, stable, report;
		int               rr;
		r = '0;
		case (it.cmd)
			CMD_SCAN: begin
				s = (slot_q > SLOT_TOP) ? SLOT_TOP : slot_q;
				hist_q[s] = it.pins;
				if (beep_on_q) begin
					phase_q = phase_q + 1;
					if (phase_q >= TOTAL_LEN)
						phase_q = 0;
					if (phase_q < ON_LEN) begin
						rr = phase_q % CYCLE_LEN;
						if (rr == 0)
							tone_q = 1'b1;
						else if (rr == MARK_TICKS)
							tone_q = 1'b0;
					end
				end
				cur    = it.pins;
				stable = ~((hist_q[0] ^ hist_q[1]) | (hist_q[1] ^ hist_q[2]));
				report = stable & (cur ^ reported_q);
				reported_q = (reported_q & ~report) | (report & cur);
				r.pressed_keys  = report & ~cur;
				r.released_keys = report & cur;
				if (s == 2'd0) begin
					r.slow_tick = 1'b1;
					slot_q = SLOT_TOP;
				end else begin
					slot_q = s - 2'd1;
				end
			end
			CMD_START: begin
				beep_on_q = 1'b1;
				phase_q   = ON_LEN;
			end
			CMD_STOP: begin
				beep_on_q = 1'b0;
				tone_q    = 1'b0;
			end
			default: ;
		endcase
		r.tone_enable = tone_q;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		if (error_count <= 100)
			$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pending_results.push_back(next_debounce_result(in_item));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", int'(out_item), 0);
				end else begin
					want = pending_results.pop_front();
					if (out_item.pressed_keys !== want.pressed_keys)
						report_mismatch("pressed_keys", int'(out_item.pressed_keys),
							int'(want.pressed_keys));
					if (out_item.released_keys !== want.released_keys)
						report_mismatch("released_keys", int'(out_item.released_keys),
							int'(want.released_keys));
					if (out_item.slow_tick !== want.slow_tick)
						report_mismatch("slow_tick", int'(out_item.slow_tick),
							int'(want.slow_tick));
					if (out_item.tone_enable !== want.tone_enable)
						report_mismatch("tone_enable", int'(out_item.tone_enable),
							int'(want.tone_enable));
				end
			end
		end
	end

	function automatic in_item_t mk_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] pins);
		in_item_t it;
		it.cmd  = cmd;
		it.pins = pins;
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		in_item_t seq [$];
		seq = '{
			mk_item(CMD_SCAN, 8'h00), mk_item(CMD_SCAN, 8'h00), mk_item(CMD_SCAN, 8'h00),
			mk_item(CMD_SCAN, 8'hFF), mk_item(CMD_SCAN, 8'hFF), mk_item(CMD_SCAN, 8'hFF),
			mk_item(CMD_SCAN, 8'h00), mk_item(CMD_SCAN, 8'h00), mk_item(CMD_SCAN, 8'h00),
			mk_item(CMD_SCAN, 8'hA5), mk_item(CMD_SCAN, 8'hA5), mk_item(CMD_SCAN, 8'h5A),
			mk_item(CMD_UNUSED, 8'hFF), mk_item(CMD_START, 8'h00),
			mk_item(CMD_SCAN, 8'h5A), mk_item(CMD_SCAN, 8'h5A),
			mk_item(CMD_STOP, 8'hFF), mk_item(CMD_SCAN, 8'hFF),
			mk_item(CMD_START, 8'hFF), mk_item(CMD_START, 8'h00),
			mk_item(CMD_STOP, 8'h00), mk_item(CMD_STOP, 8'hFF),
			mk_item(CMD_UNUSED, 8'h00), mk_item(CMD_SCAN, 8'hFF), mk_item(CMD_SCAN, 8'hFF)
		};
		foreach (seq[i])
			send_item(seq[i]);
	endtask

	// held key levels with contact bounce, plus noise and stray commands
	task automatic test_key_bounce(int n);
		logic [KEY_W-1:0] level;
		logic [KEY_W-1:0] pins;
		int               r;
		level = KEY_W'($urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 12)
				level = level ^ KEY_W'($urandom);
			pins = level;
			if ($urandom_range(3) == 0)
				pins = pins ^ KEY_W'($urandom & $urandom & $urandom);
			if (r < 80)
				send_item(mk_item(CMD_SCAN, pins));
			else if (r < 92)
				send_item(mk_item(CMD_SCAN, KEY_W'($urandom)));
			else if (r < 96)
				send_item(mk_item(CMD_UNUSED, KEY_W'($urandom)));
			else if (r < 98)
				send_item(mk_item(CMD_START, KEY_W'($urandom)));
			else
				send_item(mk_item(CMD_STOP, KEY_W'($urandom)));
		end
	endtask

	// beep sessions, most long enough to leave the pause and wrap the cadence
	task automatic test_beep_cadence(int n);
		int sent;
		int k;
		int r;
		sent = 0;
		while (sent < n) begin
			send_item(mk_item(CMD_START, KEY_W'($urandom)));
			sent++;
			k = $urandom_range(20, 90);
			for (int i = 0; i < k; i++) begin
				r = $urandom_range(99);
				if (r == 0)
					send_item(mk_item(CMD_UNUSED, KEY_W'($urandom)));
				else if (r == 1)
					send_item(mk_item(CMD_START, KEY_W'($urandom)));
				else
					send_item(mk_item(CMD_SCAN, KEY_W'($urandom)));
			end
			sent += k;
			if ($urandom_range(2) == 0) begin
				send_item(mk_item(CMD_STOP, KEY_W'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		hist_q     = '{default: '0};
		reported_q = '0;
		slot_q     = SLOT_TOP;
		beep_on_q  = 1'b0;
		phase_q    = 0;
		tone_q     = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 33;
		recv_idle_pct = 48;
		test_directed();
		test_key_bounce(300);
		test_beep_cadence(230);
		drain_results();

		send_idle_pct = 48;
		recv_idle_pct = 33;
		test_key_bounce(300);
		test_beep_cadence(230);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_key_bounce(300);
		test_beep_cadence(230);
		drain_results();

		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results missing", pending_results.size(), 0);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
